// ----- rtl/qtlc_pkg.sv -----
package qtlc_pkg;

   localparam int MaxRes   = 6;
   localparam int CntWidth = 3;

   // result kinds
   localparam logic [2:0] KIND_BYTE  = 3'd0;
   localparam logic [2:0] KIND_END   = 3'd1;
   localparam logic [2:0] KIND_OPEN  = 3'd2;
   localparam logic [2:0] KIND_CLOSE = 3'd3;
   localparam logic [2:0] KIND_EOI   = 3'd4;

   // characters of interest
   localparam logic [7:0] CH_MARK0  = 8'hEF;
   localparam logic [7:0] CH_MARK1  = 8'hBB;
   localparam logic [7:0] CH_MARK2  = 8'hBF;
   localparam logic [7:0] CH_LBRACE = 8'h7B;
   localparam logic [7:0] CH_RBRACE = 8'h7D;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_LOW_N  = 8'h6E;
   localparam logic [7:0] CH_LOW_T  = 8'h74;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_SPACE  = 8'h20;

   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] data;
      logic       quoted;
   } rsp_item_type;

   // all results caused by one input word, in order
   typedef struct packed {
      logic [CntWidth-1:0]             cnt;
      rsp_item_type [MaxRes-1:0]       item;
   } grp_type;

endpackage

// ----- rtl/qtlc_front.sv -----
module qtlc_front import qtlc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic [7:0] in_byte,
   input  logic       end_of_input,
   output grp_type    grp
);

   typedef enum logic [3:0] {
      MODE_START  = 4'd0,
      MODE_MARK1  = 4'd1,
      MODE_MARK2  = 4'd2,
      MODE_IDLE   = 4'd3,
      MODE_SLASH  = 4'd4,
      MODE_LINE   = 4'd5,
      MODE_BLOCK  = 4'd6,
      MODE_STAR   = 4'd7,
      MODE_BARE   = 4'd8,
      MODE_QUOTED = 4'd9,
      MODE_ESCAPE = 4'd10
   } mode_type;

   mode_type mode_ff;
   mode_type mode_in;

   function automatic grp_type add_item(grp_type g, logic [2:0] kind, logic [7:0] data,
                                        logic quoted);
      grp_type r;
      r = g;
      if (g.cnt < CntWidth'(MaxRes)) begin
         r.item[g.cnt].kind   = kind;
         r.item[g.cnt].data   = data;
         r.item[g.cnt].quoted = quoted;
         r.cnt                = g.cnt + CntWidth'(1);
      end
      return r;
   endfunction

   function automatic logic is_space(logic [7:0] b);
      return (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
   endfunction

   always_comb begin
      grp_type  g;
      mode_type mid;
      logic     do_bare;
      logic     do_idle;
      g       = '0;
      mid     = mode_ff;
      do_bare = 1'b0;
      do_idle = 1'b0;

      case (mode_ff)
         MODE_START: begin
            if (in_byte == CH_MARK0) mid = MODE_MARK1;
            else do_idle = 1'b1;
         end
         MODE_MARK1: begin
            if (in_byte == CH_MARK1) mid = MODE_MARK2;
            else begin
               g       = add_item(g, KIND_BYTE, CH_MARK0, 1'b0);
               do_bare = 1'b1;
            end
         end
         MODE_MARK2: begin
            if (in_byte == CH_MARK2) mid = MODE_IDLE;
            else begin
               g       = add_item(g, KIND_BYTE, CH_MARK0, 1'b0);
               g       = add_item(g, KIND_BYTE, CH_MARK1, 1'b0);
               do_bare = 1'b1;
            end
         end
         MODE_SLASH: begin
            if (in_byte == CH_SLASH) mid = MODE_LINE;
            else if (in_byte == CH_STAR) mid = MODE_BLOCK;
            else begin
               g       = add_item(g, KIND_BYTE, CH_SLASH, 1'b0);
               do_bare = 1'b1;
            end
         end
         MODE_LINE: begin
            if (in_byte == CH_LF) mid = MODE_IDLE;
         end
         MODE_BLOCK: begin
            if (in_byte == CH_STAR) mid = MODE_STAR;
         end
         MODE_STAR: begin
            if (in_byte == CH_SLASH) mid = MODE_IDLE;
            else if (in_byte != CH_STAR) mid = MODE_BLOCK;
         end
         MODE_BARE: do_bare = 1'b1;
         MODE_QUOTED: begin
            if (in_byte == CH_DQUOTE) begin
               g   = add_item(g, KIND_END, 8'h00, 1'b1);
               mid = MODE_IDLE;
            end else if (in_byte == CH_BSLASH) begin
               mid = MODE_ESCAPE;
            end else begin
               g = add_item(g, KIND_BYTE, in_byte, 1'b1);
            end
         end
         MODE_ESCAPE: begin
            if (in_byte == CH_LOW_N) g = add_item(g, KIND_BYTE, CH_LF, 1'b1);
            else if (in_byte == CH_LOW_T) g = add_item(g, KIND_BYTE, CH_TAB, 1'b1);
            else g = add_item(g, KIND_BYTE, in_byte, 1'b1);
            mid = MODE_QUOTED;
         end
         default: do_idle = 1'b1;
      endcase

      // inside a bare word: whitespace, braces and quotes close it
      if (do_bare) begin
         if (is_space(in_byte)) begin
            g   = add_item(g, KIND_END, 8'h00, 1'b0);
            mid = MODE_IDLE;
         end else if (in_byte == CH_LBRACE) begin
            g   = add_item(g, KIND_END, 8'h00, 1'b0);
            g   = add_item(g, KIND_OPEN, 8'h00, 1'b0);
            mid = MODE_IDLE;
         end else if (in_byte == CH_RBRACE) begin
            g   = add_item(g, KIND_END, 8'h00, 1'b0);
            g   = add_item(g, KIND_CLOSE, 8'h00, 1'b0);
            mid = MODE_IDLE;
         end else if (in_byte == CH_DQUOTE) begin
            g   = add_item(g, KIND_END, 8'h00, 1'b0);
            mid = MODE_QUOTED;
         end else begin
            g   = add_item(g, KIND_BYTE, in_byte, 1'b0);
            mid = MODE_BARE;
         end
      end

      // between tokens
      if (do_idle) begin
         if (is_space(in_byte)) begin
            mid = MODE_IDLE;
         end else if (in_byte == CH_LBRACE) begin
            g   = add_item(g, KIND_OPEN, 8'h00, 1'b0);
            mid = MODE_IDLE;
         end else if (in_byte == CH_RBRACE) begin
            g   = add_item(g, KIND_CLOSE, 8'h00, 1'b0);
            mid = MODE_IDLE;
         end else if (in_byte == CH_DQUOTE) begin
            mid = MODE_QUOTED;
         end else if (in_byte == CH_SLASH) begin
            mid = MODE_SLASH;
         end else begin
            g   = add_item(g, KIND_BYTE, in_byte, 1'b0);
            mid = MODE_BARE;
         end
      end

      mode_in = mid;

      // flush and close at end of text
      if (end_of_input) begin
         case (mid)
            MODE_MARK1: begin
               g = add_item(g, KIND_BYTE, CH_MARK0, 1'b0);
               g = add_item(g, KIND_END, 8'h00, 1'b0);
            end
            MODE_MARK2: begin
               g = add_item(g, KIND_BYTE, CH_MARK0, 1'b0);
               g = add_item(g, KIND_BYTE, CH_MARK1, 1'b0);
               g = add_item(g, KIND_END, 8'h00, 1'b0);
            end
            MODE_SLASH: begin
               g = add_item(g, KIND_BYTE, CH_SLASH, 1'b0);
               g = add_item(g, KIND_END, 8'h00, 1'b0);
            end
            MODE_BARE:   g = add_item(g, KIND_END, 8'h00, 1'b0);
            MODE_QUOTED: g = add_item(g, KIND_END, 8'h00, 1'b1);
            MODE_ESCAPE: begin
               g = add_item(g, KIND_BYTE, CH_BSLASH, 1'b1);
               g = add_item(g, KIND_END, 8'h00, 1'b1);
            end
            default: ;
         endcase
         g       = add_item(g, KIND_EOI, 8'h00, 1'b0);
         mode_in = MODE_START;
      end

      grp = g;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_START;
      end else if (accept) begin
         mode_ff <= mode_in;
      end
   end

endmodule

// ----- rtl/qtlc_queue.sv -----
module qtlc_queue import qtlc_pkg::*; #(
   parameter int Depth = 4
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  grp_type push_grp,
   input  logic    pop,
   output grp_type head,
   output logic    not_empty,
   output logic    full
);

   localparam int PtrWidth = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int FillWidth = $clog2(Depth + 1);

   grp_type               data_ff [Depth];
   logic [PtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FillWidth-1:0]  fill_ff, fill_in;

   function automatic logic [PtrWidth-1:0] bump(logic [PtrWidth-1:0] p);
      return (p == PtrWidth'(Depth - 1)) ? '0 : p + PtrWidth'(1);
   endfunction

   always_comb begin
      wr_ptr_in = push ? bump(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? bump(rd_ptr_ff) : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !pop) fill_in = fill_ff + FillWidth'(1);
      else if (pop && !push) fill_in = fill_ff - FillWidth'(1);
   end

   assign head      = data_ff[rd_ptr_ff];
   assign not_empty = (fill_ff != '0);
   assign full      = (fill_ff == FillWidth'(Depth));

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) data_ff[wr_ptr_ff] <= push_grp;
   end

endmodule

// ----- rtl/qtlc_back.sv -----
module qtlc_back import qtlc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  grp_type    head,
   input  logic       not_empty,
   output logic       pop,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [2:0] rsp_kind,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_quoted,
   output logic       rsp_last
);

   logic [CntWidth-1:0] idx_ff, idx_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [2:0]          kind_ff;
   logic [7:0]          byte_ff;
   logic                quoted_ff;
   logic                last_ff;
   logic                load;
   logic                at_end;
   rsp_item_type        cur;

   assign cur    = head.item[idx_ff];
   assign at_end = (idx_ff == (head.cnt - CntWidth'(1)));
   assign load   = not_empty && (!rsp_valid_ff || !rsp_stall);
   assign pop    = load && at_end;

   always_comb begin
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         idx_in       = at_end ? '0 : idx_ff + CntWidth'(1);
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         kind_ff   <= cur.kind;
         byte_ff   <= cur.data;
         quoted_ff <= cur.quoted;
         last_ff   <= at_end;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_kind     = kind_ff;
   assign rsp_out_byte = byte_ff;
   assign rsp_quoted   = quoted_ff;
   assign rsp_last     = last_ff;

endmodule

// ----- rtl/quoted_token_lexer_with_comments_top.sv -----
// The first result word of an input word is written to the group queue, then loaded into the output register.
// Throughput: one input word per cycle while each word yields at most one result word
// and rsp_stall stays low; the output register takes a word's results one at a time, the group
// queue absorbing the difference until it fills and raises req_stall.
// Reset (synchronous, active high): lexer returns to start of text with mark check
// pending, the group queue and output register empty; req_stall is held high throughout.
module quoted_token_lexer_with_comments_top import qtlc_pkg::*; #(
   parameter int QueueDepth = 4
) (
   input  logic       clock,
   input  logic       reset,
   // input channel
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   input  logic       req_end_of_input,
   // result channel
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [2:0] rsp_kind,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_quoted,
   output logic       rsp_last
);

   logic    accept;
   logic    q_full;
   logic    q_not_empty;
   logic    q_pop;
   grp_type front_grp;
   grp_type q_head;

   // Hold the input while in reset or when the group queue has no room; the front
   // never waits on the output side directly.
   assign req_stall = q_full || reset;
   assign accept    = req_valid && !req_stall;

   // Front: advance the lexer mode and gather every result word of this byte.
   qtlc_front u_front (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .in_byte      (req_in_byte),
      .end_of_input (req_end_of_input),
      .grp          (front_grp)
   );

   // Queue: drop groups that carry nothing (whitespace, comments, mark bytes).
   qtlc_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (accept && (front_grp.cnt != '0)),
      .push_grp  (front_grp),
      .pop       (q_pop),
      .head      (q_head),
      .not_empty (q_not_empty),
      .full      (q_full)
   );

   // Back: walk the head group one result word per cycle, while rsp_stall lets the output
   // register move, flagging the final word of the group as last.
   qtlc_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head         (q_head),
      .not_empty    (q_not_empty),
      .pop          (q_pop),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_kind     (rsp_kind),
      .rsp_out_byte (rsp_out_byte),
      .rsp_quoted   (rsp_quoted),
      .rsp_last     (rsp_last)
   );

endmodule
